// ===== design/command_line_tokenizer_macros.svh =====
// Assertion macros shared by the command line tokenizer RTL.
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CLT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("command_line_tokenizer: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define CLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("command_line_tokenizer: next-cycle check failed");

`endif

// ===== design/clt_pkg.sv =====
// Types, codes and helpers shared by the command line tokenizer modules.
`default_nettype none

package clt_pkg;

    // Default argument limit and register reset value.
    localparam logic [7:0] DEFAULT_MAX_ARGS = 8'd255;

    // Result queue geometry.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = RQ_AW + 1;

    // Event kinds carried in a result word.
    localparam logic [2:0] K_START = 3'd0;
    localparam logic [2:0] K_CHAR  = 3'd1;
    localparam logic [2:0] K_END   = 3'd2;
    localparam logic [2:0] K_ERROR = 3'd3;
    localparam logic [2:0] K_DONE  = 3'd4;

    // Input operations.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Characters with a special meaning.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Scanner states.
    typedef enum logic [2:0] {
        SC_SKIP  = 3'd0,
        SC_ARG   = 3'd2,
        SC_QUOTE = 3'd3,
        SC_ESC   = 3'd4,
        SC_QESC  = 3'd5
    } scan_t;

    typedef struct packed {
        logic       op;
        logic [7:0] char_in;
    } in_word_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_out;
        logic [7:0] arg_index;
        logic [7:0] arg_total;
        logic       status;
        logic       last;
    } out_word_t;

    // Builds a result word with the last flag clear.
    function automatic out_word_t make_word(input logic [2:0] kind,
                                            input logic [7:0] ch,
                                            input logic [7:0] idx,
                                            input logic [7:0] total,
                                            input logic       status);
        out_word_t w;
        w.kind      = kind;
        w.char_out  = ch;
        w.arg_index = idx;
        w.arg_total = total;
        w.status    = status;
        w.last      = 1'b0;
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/clt_rq.sv =====
// Result queue: takes up to two result words a cycle and hands out one.
`default_nettype none

module clt_rq (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire [1:0]            push_cnt,
    input  clt_pkg::out_word_t   push_word0,
    input  clt_pkg::out_word_t   push_word1,
    output logic                 room,
    output logic                 out_valid,
    input  wire                  out_stall,
    output clt_pkg::out_word_t   out_word,
    output logic [clt_pkg::RQ_CW-1:0] level
);
    import clt_pkg::*;

    out_word_t        mem [RQ_DEPTH];
    logic [RQ_AW-1:0] wr_ptr_reg;
    logic [RQ_AW-1:0] wr_ptr_next;
    logic [RQ_AW-1:0] rd_ptr_reg;
    logic [RQ_AW-1:0] rd_ptr_next;
    logic [RQ_CW-1:0] count_reg;
    logic [RQ_CW-1:0] count_next;
    logic             pop;

    // Handshake towards the output and towards the scanner.
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= RQ_CW'(RQ_DEPTH - 2));
    assign out_word  = mem[rd_ptr_reg];
    assign level     = count_reg;

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + RQ_AW'(pop);
        count_next  = count_reg + RQ_CW'(push_cnt) - RQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: the second word of a pair lands in the slot after the first.
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_word0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + RQ_AW'(1)] <= push_word1;
        end
    end

endmodule

`default_nettype wire

// ===== design/clt_scan.sv =====
// Input register, scanner state machine and event decode for one byte.
`default_nettype none

module clt_scan #(
    parameter logic [7:0] MAX_ARGS = clt_pkg::DEFAULT_MAX_ARGS
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  clt_pkg::in_word_t   in_word,
    input  wire [7:0]           max_args,
    input  wire                 room,
    output logic [1:0]          push_cnt,
    output clt_pkg::out_word_t  push_word0,
    output clt_pkg::out_word_t  push_word1
);
    import clt_pkg::*;

    logic       stage_valid_reg;
    logic       stage_valid_next;
    in_word_t   stage_word_reg;
    scan_t      scan_reg;
    scan_t      scan_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic       ovf_reg;
    logic       ovf_next;

    logic       accept;
    logic       stage_go;
    logic [7:0] ch;
    logic       is_end;
    logic       is_blank;
    logic       is_quote;
    logic       is_bslash;
    logic       in_arg;
    logic [7:0] limit;
    logic [7:0] cur;
    logic [7:0] count_inc;
    logic       at_limit;
    logic [1:0] num;
    out_word_t  w0;
    out_word_t  w1;

    // Input stage: a held word moves on once the queue has room for a pair.
    assign stage_go  = stage_valid_reg && room;
    assign in_stall  = stage_valid_reg && !room;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_go)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // Classification of the held byte against the current state.
    always_comb
    begin
        ch        = stage_word_reg.char_in;
        is_end    = (stage_word_reg.op == OP_END) || (ch == CH_NUL);
        is_blank  = ch inside {8'h20, [8'h09:8'h0D]};
        is_quote  = (ch == CH_QUOTE);
        is_bslash = (ch == CH_BSLASH);
        in_arg    = scan_reg inside {SC_ARG, SC_QUOTE, SC_ESC, SC_QESC};
        limit     = (max_args < MAX_ARGS) ? max_args : MAX_ARGS;
        cur       = (count_reg != 8'd0) ? (count_reg - 8'd1) : 8'd0;
        count_inc = count_reg + 8'd1;
        at_limit  = (count_reg >= limit);
    end

    // Next state of the scanner.
    always_comb
    begin
        scan_next  = scan_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (is_end)
        begin
            scan_next  = SC_SKIP;
            count_next = 8'd0;
            ovf_next   = 1'b0;
        end
        else if (!ovf_reg)
        begin
            case (scan_reg)
                SC_ARG:
                begin
                    if (is_blank)
                    begin
                        scan_next = SC_SKIP;
                    end
                    else if (is_quote)
                    begin
                        scan_next = SC_QUOTE;
                    end
                    else if (is_bslash)
                    begin
                        scan_next = SC_ESC;
                    end
                end
                SC_QUOTE:
                begin
                    if (is_quote)
                    begin
                        scan_next = SC_ARG;
                    end
                    else if (is_bslash)
                    begin
                        scan_next = SC_QESC;
                    end
                end
                SC_ESC:
                begin
                    scan_next = SC_ARG;
                end
                SC_QESC:
                begin
                    scan_next = SC_QUOTE;
                end
                default:
                begin
                    scan_next = SC_SKIP;
                    if (!is_blank)
                    begin
                        if (at_limit)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_inc;
                            if (is_quote)
                            begin
                                scan_next = SC_QUOTE;
                            end
                            else if (is_bslash)
                            begin
                                scan_next = SC_ESC;
                            end
                            else
                            begin
                                scan_next = SC_ARG;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Result words produced by the held byte.
    always_comb
    begin
        w0  = '0;
        w1  = '0;
        num = 2'd0;
        if (is_end)
        begin
            if (!ovf_reg && in_arg)
            begin
                w0  = make_word(K_END, 8'd0, cur, count_reg, ovf_reg);
                w1  = make_word(K_DONE, 8'd0, 8'd0, count_reg, ovf_reg);
                num = 2'd2;
            end
            else
            begin
                w0  = make_word(K_DONE, 8'd0, 8'd0, count_reg, ovf_reg);
                num = 2'd1;
            end
        end
        else if (!ovf_reg)
        begin
            case (scan_reg)
                SC_ARG:
                begin
                    if (is_blank)
                    begin
                        w0  = make_word(K_END, 8'd0, cur, count_reg, 1'b0);
                        num = 2'd1;
                    end
                    else if (!is_quote && !is_bslash)
                    begin
                        w0  = make_word(K_CHAR, ch, cur, count_reg, 1'b0);
                        num = 2'd1;
                    end
                end
                SC_QUOTE:
                begin
                    if (!is_quote && !is_bslash)
                    begin
                        w0  = make_word(K_CHAR, ch, cur, count_reg, 1'b0);
                        num = 2'd1;
                    end
                end
                SC_ESC, SC_QESC:
                begin
                    w0  = make_word(K_CHAR, ch, cur, count_reg, 1'b0);
                    num = 2'd1;
                end
                default:
                begin
                    if (!is_blank)
                    begin
                        if (at_limit)
                        begin
                            w0  = make_word(K_ERROR, 8'd0, count_reg, count_reg, 1'b1);
                            num = 2'd1;
                        end
                        else
                        begin
                            w0  = make_word(K_START, 8'd0, count_reg, count_inc, 1'b0);
                            num = 2'd1;
                            if (!is_quote && !is_bslash)
                            begin
                                w1  = make_word(K_CHAR, ch, count_reg, count_inc, 1'b0);
                                num = 2'd2;
                            end
                        end
                    end
                end
            endcase
        end

        // Mark the final word of this byte.
        if (num == 2'd1)
        begin
            w0.last = 1'b1;
        end
        if (num == 2'd2)
        begin
            w1.last = 1'b1;
        end
    end

    assign push_cnt   = stage_go ? num : 2'd0;
    assign push_word0 = w0;
    assign push_word1 = w1;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            scan_reg        <= SC_SKIP;
            count_reg       <= 8'd0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (stage_go)
            begin
                scan_reg  <= scan_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Held input word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_word_reg <= in_word;
        end
    end

endmodule

`default_nettype wire

// ===== design/command_line_tokenizer.sv =====
// Command line tokenizer top level: splits a byte string into arguments and reports
// each one as a stream of event words (argument start, kept character, argument end,
// too-many error, done). Whitespace separates arguments, double quotes keep whitespace,
// a backslash makes the next byte literal, and quotes and escaping backslashes are
// dropped. An end word, or a zero byte, closes any open argument and reports the count
// and status, then rearms the scanner. One byte is taken per cycle unless the input
// stalls: it is held in an input register, decoded from it by the scanner state machine,
// and its zero, one or two event words enter a four-word result queue, which offers
// them on the output. The output side takes one word per cycle while out_stall is low,
// so a byte that both opens an argument and keeps a character yields two words;
// a held byte waits, and the input stalls, while the queue holds more than two words.
// The register max_args (reset 255) limits the argument count together with MAX_ARGS.
`default_nettype none
`include "command_line_tokenizer_macros.svh"

module command_line_tokenizer #(
    parameter logic [7:0] MAX_ARGS = clt_pkg::DEFAULT_MAX_ARGS
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  clt_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  wire                 out_stall,
    output clt_pkg::out_word_t  out_word,
    input  wire                 cfg_we,
    input  wire [7:0]           cfg_data
);
    import clt_pkg::*;

    logic [7:0]       max_args_reg;
    logic [1:0]       push_cnt;
    out_word_t        push_word0;
    out_word_t        push_word1;
    logic             room;
    logic [RQ_CW-1:0] level;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_args_reg <= DEFAULT_MAX_ARGS;
        end
        else if (cfg_we)
        begin
            max_args_reg <= cfg_data;
        end
    end

    // Scanner: input register, state machine and event decode.
    clt_scan #(
        .MAX_ARGS (MAX_ARGS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .max_args   (max_args_reg),
        .room       (room),
        .push_cnt   (push_cnt),
        .push_word0 (push_word0),
        .push_word1 (push_word1)
    );

    // Result queue towards the output channel.
    clt_rq u_rq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_word0 (push_word0),
        .push_word1 (push_word1),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .level      (level)
    );

    // A pair of words is always a start followed by a character, or an end followed by done.
    `CLT_ASSERT_IMPL(a_pair_order, push_cnt == 2'd2, (push_word0.kind == K_START && push_word1.kind == K_CHAR) || (push_word0.kind == K_END && push_word1.kind == K_DONE))
    // Only the second word of a pair carries the last flag.
    `CLT_ASSERT_IMPL(a_pair_last, push_cnt == 2'd2, !push_word0.last && push_word1.last)
    // An error word always reports the overflow status and ends its byte.
    `CLT_ASSERT_IMPL(a_error_word, out_valid && out_word.kind == K_ERROR, out_word.status && out_word.last)
    // The queue never overfills.
    `CLT_ASSERT_NEXT(a_queue_bound, push_cnt != 2'd0, level <= RQ_CW'(RQ_DEPTH))

endmodule

`default_nettype wire
